[hw/rtl/rlsp_pkg.sv]
// ============================================================================
// Range-limited shortest path: shared package
// Widths, codes, transaction types and small helper functions used by the
// range-limited shortest path block and its sub-modules.
// ============================================================================
package rlsp_pkg;

    // Storage sizing
    localparam int MAX_NODES  = 128;
    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int CELL_BITS  = 2 * NODE_BITS;
    localparam int DIST_BITS  = 24;

    // Fixed field widths of the transactions and registers
    localparam int NODE_FIELD_BITS = 7;
    localparam int WEIGHT_BITS     = 16;
    localparam int COUNT_BITS      = 8;
    localparam int LIMIT_BITS      = 24;
    localparam int PATH_BITS       = 24;
    localparam int COST_BITS       = 25;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 24;
    localparam int WIDE_BITS       = 34;

    typedef logic [DIST_BITS-1:0]       dist_t;
    typedef logic [NODE_BITS-1:0]       node_idx_t;
    typedef logic [CELL_BITS-1:0]       cell_addr_t;
    typedef logic [NODE_FIELD_BITS-1:0] node_field_t;
    typedef logic [WIDE_BITS-1:0]       wide_t;

    // Distance meaning "no path"
    localparam dist_t INF_DIST = {DIST_BITS{1'b1}};

    // Saturation limits of the result fields
    localparam wide_t PATH_MAX = WIDE_BITS'((64'd1 << PATH_BITS) - 64'd1);
    localparam wide_t COST_MAX = WIDE_BITS'((64'd1 << COST_BITS) - 64'd1);

    // Command codes
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_MARK    = 2'd1,
        OP_EDGE    = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NODE_COUNT  = 2'd0,
        REG_RANGE_LIMIT = 2'd1,
        REG_SOURCE_NODE = 2'd2,
        REG_TARGET_NODE = 2'd3
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_FW_ROW,
        S_FW_COL,
        S_BUILD_ROW,
        S_BUILD_COL,
        S_READ,
        S_REPORT
    } state_t;

    // Command transaction
    typedef struct packed {
        op_t                       operation;
        node_field_t               first_node;
        node_field_t               second_node;
        logic [WEIGHT_BITS-1:0]    edge_weight;
    } command_t;

    // Result transaction
    typedef struct packed {
        logic                      unreachable;
        logic [PATH_BITS-1:0]      path_distance;
        logic [COST_BITS-1:0]      adjusted_cost;
    } result_t;

    // Whether a node field names a node that the matrices hold.
    function automatic logic node_in_array(input node_field_t node);
        return int'(node) < MAX_NODES;
    endfunction

    // Node field to matrix index.
    function automatic node_idx_t node_idx(input node_field_t node);
        return NODE_BITS'(node);
    endfunction

    // Edge weight limited to the distance range.
    function automatic dist_t clip_weight(input logic [WEIGHT_BITS-1:0] weight);
        logic [63:0] wide;
        wide = 64'(weight);
        return (wide >= 64'(INF_DIST)) ? INF_DIST : DIST_BITS'(wide);
    endfunction

endpackage

[hw/rtl/range_limited_shortest_path.sv]
// ============================================================================
// Range-limited shortest path: top level
// Throughput: one command at a time; busy is high until it completes. The
//   compute time is set by one relaxation unit working one matrix cell per
//   cycle on a memory with two read ports and one write port.
// Reset: registers return to their defaults and a clearing pass fills the
//   whole road matrix while busy is high. The result strobe lasts one cycle;
//   the receiver cannot stall.
// ============================================================================
module range_limited_shortest_path (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  rlsp_pkg::command_t                      command,
    output logic                                    result_valid,
    output rlsp_pkg::result_t                       result,
    input  logic                                    cfg_write_en,
    input  rlsp_pkg::cfg_reg_t                      cfg_index,
    input  logic [rlsp_pkg::CFG_DATA_BITS-1:0]      cfg_write_data
);
    import rlsp_pkg::*;

    localparam node_idx_t LAST_NODE = NODE_BITS'(MAX_NODES - 1);

    // Configuration registers
    logic [COUNT_BITS-1:0] node_count_reg;
    logic [LIMIT_BITS-1:0] range_limit_reg;
    node_field_t           source_node_reg;
    node_field_t           target_node_reg;

    // Sequencer registers
    state_t    state_reg, state_next;
    node_idx_t row_reg, row_next;
    node_idx_t col_reg, col_next;
    node_idx_t hub_reg, hub_next;
    node_idx_t last_reg, last_next;
    logic      station_pass_reg, station_pass_next;

    // Payload registers
    dist_t       hub_dist_reg;
    logic        row_station_reg;
    node_field_t edge_from_reg;
    node_field_t edge_to_reg;
    dist_t       edge_weight_reg;
    logic [MAX_NODES-1:0] mark_reg;

    // Relaxation write-back stage
    logic       fw_valid_reg;
    logic       fw_station_reg;
    cell_addr_t fw_addr_reg;

    // Station graph build stage
    logic       bld_valid_reg;
    cell_addr_t bld_addr_reg;
    logic       bld_diag_reg;
    logic       bld_col_station_reg;

    // Result register
    logic    result_valid_reg;
    result_t result_reg;

    // Combinational controls
    logic       fw_issue;
    logic       bld_issue;
    logic       hub_latch;
    logic       row_station_latch;
    logic       mark_set;
    logic       mark_clear;
    logic       report;
    cell_addr_t read_addr_a;
    cell_addr_t read_addr_b;
    logic       road_we;
    cell_addr_t road_waddr;
    dist_t      road_wdata;
    logic       road_we_all;
    cell_addr_t road_waddr_all;
    dist_t      road_wdata_all;
    logic       station_we;
    cell_addr_t station_waddr;
    dist_t      station_wdata;

    // Memory read data and relaxation unit signals
    dist_t road_qa, road_qb, station_qa, station_qb;
    dist_t onward_dist, current_dist, via_dist;
    logic  improves;

    // Station lookup
    node_idx_t lookup_idx;
    logic      lookup_station;

    // Result arithmetic
    logic    endpoint_out;
    wide_t   dist_wide;
    wide_t   limit_wide;
    wide_t   cost_wide;
    result_t result_calc;

    // ------------------------------------------------------------------
    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= COUNT_BITS'(1);
            range_limit_reg <= '0;
            source_node_reg <= '0;
            target_node_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_reg  <= cfg_write_data[COUNT_BITS-1:0];
                REG_RANGE_LIMIT: range_limit_reg <= cfg_write_data[LIMIT_BITS-1:0];
                REG_SOURCE_NODE: source_node_reg <= cfg_write_data[NODE_FIELD_BITS-1:0];
                REG_TARGET_NODE: target_node_reg <= cfg_write_data[NODE_FIELD_BITS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Distance matrices.
    rlsp_ram #(
        .DATA_BITS (DIST_BITS),
        .ADDR_BITS (CELL_BITS)
    ) u_road_ram (
        .clk         (clk),
        .write_en    (road_we_all),
        .write_addr  (road_waddr_all),
        .write_data  (road_wdata_all),
        .read_addr_a (read_addr_a),
        .read_addr_b (read_addr_b),
        .read_data_a (road_qa),
        .read_data_b (road_qb)
    );

    rlsp_ram #(
        .DATA_BITS (DIST_BITS),
        .ADDR_BITS (CELL_BITS)
    ) u_station_ram (
        .clk         (clk),
        .write_en    (station_we),
        .write_addr  (station_waddr),
        .write_data  (station_wdata),
        .read_addr_a (read_addr_a),
        .read_addr_b (read_addr_b),
        .read_data_a (station_qa),
        .read_data_b (station_qb)
    );

    // ------------------------------------------------------------------
    // Shared relaxation unit, fed from the matrix of the pass in progress.
    assign onward_dist  = fw_station_reg ? station_qa : road_qa;
    assign current_dist = fw_station_reg ? station_qb : road_qb;

    rlsp_relax u_relax (
        .hub_dist     (hub_dist_reg),
        .onward_dist  (onward_dist),
        .current_dist (current_dist),
        .via_dist     (via_dist),
        .improves     (improves)
    );

    // ------------------------------------------------------------------
    // Whether a node counts as a station; one lookup per cycle.
    always_comb
    begin
        lookup_idx     = (state_reg == S_BUILD_ROW) ? row_reg : col_reg;
        lookup_station = mark_reg[lookup_idx]
                       || (int'(lookup_idx) == int'(source_node_reg))
                       || (int'(lookup_idx) == int'(target_node_reg));
    end

    // ------------------------------------------------------------------
    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            row_reg          <= '0;
            col_reg          <= '0;
            hub_reg          <= '0;
            last_reg         <= '0;
            station_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            hub_reg          <= hub_next;
            last_reg         <= last_next;
            station_pass_reg <= station_pass_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer next state and controls.
    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        hub_next          = hub_reg;
        last_next         = last_reg;
        station_pass_next = station_pass_reg;
        fw_issue          = 1'b0;
        bld_issue         = 1'b0;
        hub_latch         = 1'b0;
        row_station_latch = 1'b0;
        mark_set          = 1'b0;
        mark_clear        = 1'b0;
        report            = 1'b0;
        read_addr_a       = {row_reg, col_reg};
        read_addr_b       = {row_reg, col_reg};
        road_we           = 1'b0;
        road_waddr        = {row_reg, col_reg};
        road_wdata        = INF_DIST;

        unique case (state_reg)
            // Fill the road matrix: zero diagonal, no path elsewhere.
            S_CLEAR:
            begin
                road_we    = 1'b1;
                road_wdata = (row_reg == col_reg) ? '0 : INF_DIST;
                col_next   = col_reg + 1'b1;
                if (col_reg == LAST_NODE)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (row_reg == LAST_NODE)
                    begin
                        row_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            // Take a command.
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (command.operation)
                        OP_CLEAR:
                        begin
                            mark_clear = 1'b1;
                            row_next   = '0;
                            col_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_MARK:
                        begin
                            mark_set = node_in_array(command.first_node);
                        end
                        OP_EDGE:
                        begin
                            if (node_in_array(command.first_node)
                                && node_in_array(command.second_node)
                                && (command.first_node != command.second_node))
                            begin
                                road_we    = 1'b1;
                                road_waddr = {node_idx(command.first_node),
                                              node_idx(command.second_node)};
                                road_wdata = clip_weight(command.edge_weight);
                                state_next = S_EDGE;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            // Nodes in use: zero acts as one, clamped to the array.
                            if (node_count_reg == '0)
                            begin
                                last_next = '0;
                            end
                            else if (int'(node_count_reg) > MAX_NODES)
                            begin
                                last_next = LAST_NODE;
                            end
                            else
                            begin
                                last_next = NODE_BITS'(node_count_reg - COUNT_BITS'(1));
                            end
                            row_next          = '0;
                            col_next          = '0;
                            hub_next          = '0;
                            station_pass_next = 1'b0;
                            state_next        = S_FW_ROW;
                        end
                    endcase
                end
            end

            // Mirror entry of an undirected edge.
            S_EDGE:
            begin
                road_we    = 1'b1;
                road_waddr = {node_idx(edge_to_reg), node_idx(edge_from_reg)};
                road_wdata = edge_weight_reg;
                state_next = S_IDLE;
            end

            // Fetch the distance from this row to the hub node.
            S_FW_ROW:
            begin
                read_addr_a = {row_reg, hub_reg};
                col_next    = '0;
                state_next  = S_FW_COL;
            end

            // Relax one cell of the row through the hub node.
            S_FW_COL:
            begin
                read_addr_a = {hub_reg, col_reg};
                read_addr_b = {row_reg, col_reg};
                fw_issue    = 1'b1;
                hub_latch   = (col_reg == '0);
                col_next    = col_reg + 1'b1;
                if (col_reg == last_reg)
                begin
                    col_next   = '0;
                    row_next   = row_reg + 1'b1;
                    state_next = S_FW_ROW;
                    if (row_reg == last_reg)
                    begin
                        row_next = '0;
                        hub_next = hub_reg + 1'b1;
                        if (hub_reg == last_reg)
                        begin
                            hub_next   = '0;
                            state_next = station_pass_reg ? S_READ : S_BUILD_ROW;
                        end
                    end
                end
            end

            // Look up whether the row node is a station.
            S_BUILD_ROW:
            begin
                row_station_latch = 1'b1;
                col_next          = '0;
                state_next        = S_BUILD_COL;
            end

            // Write one station graph cell from the road distance.
            S_BUILD_COL:
            begin
                read_addr_a = {row_reg, col_reg};
                bld_issue   = 1'b1;
                col_next    = col_reg + 1'b1;
                if (col_reg == last_reg)
                begin
                    col_next   = '0;
                    row_next   = row_reg + 1'b1;
                    state_next = S_BUILD_ROW;
                    if (row_reg == last_reg)
                    begin
                        row_next          = '0;
                        hub_next          = '0;
                        station_pass_next = 1'b1;
                        state_next        = S_FW_ROW;
                    end
                end
            end

            // Fetch the source-to-target station distance.
            S_READ:
            begin
                read_addr_a = {node_idx(source_node_reg), node_idx(target_node_reg)};
                state_next  = S_REPORT;
            end

            S_REPORT:
            begin
                report     = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // ------------------------------------------------------------------
    // Station write port: graph build or relaxation write-back.
    always_comb
    begin
        station_we    = 1'b0;
        station_waddr = fw_addr_reg;
        station_wdata = via_dist;
        if (bld_valid_reg)
        begin
            station_we    = 1'b1;
            station_waddr = bld_addr_reg;
            if (bld_diag_reg)
            begin
                station_wdata = '0;
            end
            else if (row_station_reg && bld_col_station_reg && (road_qa != INF_DIST)
                     && (64'(road_qa) <= 64'(range_limit_reg)))
            begin
                station_wdata = road_qa;
            end
            else
            begin
                station_wdata = INF_DIST;
            end
        end
        else if (fw_valid_reg && fw_station_reg && improves)
        begin
            station_we = 1'b1;
        end
    end

    // The road write-back shares the road write port with the command writes,
    // which never run during a shortest-path pass.
    always_comb
    begin
        road_we_all    = road_we;
        road_waddr_all = road_waddr;
        road_wdata_all = road_wdata;
        if (fw_valid_reg && !fw_station_reg && improves)
        begin
            road_we_all    = 1'b1;
            road_waddr_all = fw_addr_reg;
            road_wdata_all = via_dist;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline stages and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg     <= 1'b0;
            bld_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            mark_reg         <= '0;
        end
        else
        begin
            fw_valid_reg     <= fw_issue;
            bld_valid_reg    <= bld_issue;
            result_valid_reg <= report;
            if (mark_clear)
            begin
                mark_reg <= '0;
            end
            else if (mark_set)
            begin
                mark_reg[node_idx(command.first_node)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fw_station_reg      <= station_pass_reg;
        fw_addr_reg         <= {row_reg, col_reg};
        bld_addr_reg        <= {row_reg, col_reg};
        bld_diag_reg        <= (row_reg == col_reg);
        bld_col_station_reg <= lookup_station;
        if (hub_latch)
        begin
            hub_dist_reg <= station_pass_reg ? station_qa : road_qa;
        end
        if (row_station_latch)
        begin
            row_station_reg <= lookup_station;
        end
        if (start && (state_reg == S_IDLE))
        begin
            edge_from_reg   <= command.first_node;
            edge_to_reg     <= command.second_node;
            edge_weight_reg <= clip_weight(command.edge_weight);
        end
        if (report)
        begin
            result_reg <= result_calc;
        end
    end

    // ------------------------------------------------------------------
    // Result: distance saturated to the field, adjusted cost above the limit.
    always_comb
    begin
        endpoint_out = (int'(source_node_reg) > int'(last_reg))
                    || (int'(target_node_reg) > int'(last_reg));
        dist_wide    = WIDE_BITS'(station_qa);
        limit_wide   = WIDE_BITS'(range_limit_reg);
        if (dist_wide < limit_wide)
        begin
            cost_wide = dist_wide;
        end
        else
        begin
            cost_wide = (dist_wide << 1) - limit_wide;
        end

        if (endpoint_out || (station_qa == INF_DIST))
        begin
            result_calc.unreachable   = 1'b1;
            result_calc.path_distance = '1;
            result_calc.adjusted_cost = '0;
        end
        else
        begin
            result_calc.unreachable   = 1'b0;
            result_calc.path_distance = (dist_wide > PATH_MAX) ? '1
                                      : dist_wide[PATH_BITS-1:0];
            result_calc.adjusted_cost = (cost_wide > COST_MAX) ? '1
                                      : cost_wide[COST_BITS-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hw/rtl/rlsp_ram.sv]
// ============================================================================
// Range-limited shortest path: distance matrix memory
// Generic memory with one write port and two read ports; read data is
// registered and appears in the cycle after the address.
// ============================================================================
module rlsp_ram #(
    parameter int DATA_BITS = 24,
    parameter int ADDR_BITS = 14
) (
    input  logic                 clk,
    input  logic                 write_en,
    input  logic [ADDR_BITS-1:0] write_addr,
    input  logic [DATA_BITS-1:0] write_data,
    input  logic [ADDR_BITS-1:0] read_addr_a,
    input  logic [ADDR_BITS-1:0] read_addr_b,
    output logic [DATA_BITS-1:0] read_data_a,
    output logic [DATA_BITS-1:0] read_data_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[write_addr] <= write_data;
        end
    end

    // Registered read ports; a read of a cell written in the same cycle
    // returns the old contents.
    always_ff @(posedge clk)
    begin
        read_data_a <= mem[read_addr_a];
        read_data_b <= mem[read_addr_b];
    end

endmodule

[hw/rtl/rlsp_relax.sv]
// ============================================================================
// Range-limited shortest path: relaxation unit
// Saturating sum of two distances and comparison against the current
// distance, shared by both shortest-path passes.
// ============================================================================
module rlsp_relax (
    input  rlsp_pkg::dist_t hub_dist,
    input  rlsp_pkg::dist_t onward_dist,
    input  rlsp_pkg::dist_t current_dist,
    output rlsp_pkg::dist_t via_dist,
    output logic            improves
);
    import rlsp_pkg::*;

    logic [DIST_BITS:0] sum;

    // Sum saturates at the "no path" value.
    always_comb
    begin
        sum = {1'b0, hub_dist} + {1'b0, onward_dist};
        if (sum >= {1'b0, INF_DIST})
        begin
            via_dist = INF_DIST;
        end
        else
        begin
            via_dist = sum[DIST_BITS-1:0];
        end
        improves = via_dist < current_dist;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Range-limited shortest path: testbench
// Loads graphs of marked stations and weighted edges into the block, issues
// compute commands and checks each reported transaction against an in-bench
// predictor that runs the same two all-pairs closures. A short directed part
// comes first, then random graphs under changing register settings and
// finally one larger graph.
// ============================================================================
module tb;
    import rlsp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1360;
    localparam int BIG_NODES      = 48;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 50;
    // Slowest single command is the large compute.
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int LIMIT_NEAR_MAX = 16777214;
    localparam int LIMIT_ALL_ONES = 16777215;

    // Matrix selectors for the predictor
    localparam int ROAD_MAT    = 0;
    localparam int STATION_MAT = 1;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    command_t                 command;
    logic                     result_valid;
    result_t                  result;
    logic                     cfg_write_en;
    cfg_reg_t                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_write_data;

    // Predictor state and register copies
    dist_t                    dist_mat [2][MAX_NODES][MAX_NODES];
    logic                     station_marked [MAX_NODES];
    logic [COUNT_BITS-1:0]    cfg_nodes;
    logic [LIMIT_BITS-1:0]    cfg_limit;
    node_field_t              cfg_source;
    node_field_t              cfg_target;

    command_t                 pending_commands [$];
    result_t                  expected_results [$];
    result_t                  oldest_result;
    bit                       in_flight    = 1'b0;
    int                       gap_percent  = 0;
    int                       failures     = 0;
    int                       quiet_cycles = 0;
    int                       items_queued = 0;

    range_limited_shortest_path i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .result_valid   (result_valid),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Fill a matrix with "no path" everywhere except the zero diagonal.
    function automatic void fill_matrix(input int m);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            for (int j = 0; j < MAX_NODES; j++)
            begin
                dist_mat[m][i][j] = (i == j) ? '0 : INF_DIST;
            end
        end
    endfunction

    function automatic void wipe_graph();
        fill_matrix(ROAD_MAT);
        fill_matrix(STATION_MAT);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            station_marked[i] = 1'b0;
        end
    endfunction

    // Source and target count as stations without being stored as marks.
    function automatic logic is_station(input int node);
        return station_marked[node] || node == int'(cfg_source) || node == int'(cfg_target);
    endfunction

    // All-pairs closure over the first n nodes, sums saturating at "no path".
    function automatic void close_matrix(input int m, input int n);
        logic [DIST_BITS:0] via;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    via = {1'b0, dist_mat[m][i][k]} + {1'b0, dist_mat[m][k][j]};
                    if (via >= {1'b0, INF_DIST})
                    begin
                        via = {1'b0, INF_DIST};
                    end
                    if (via < {1'b0, dist_mat[m][i][j]})
                    begin
                        dist_mat[m][i][j] = via[DIST_BITS-1:0];
                    end
                end
            end
        end
    endfunction

    // Apply one accepted command to the predictor; a compute queues its result.
    function automatic void predict_command(input command_t c);
        int                   n;
        dist_t                d;
        logic [DIST_BITS+1:0] cost;
        result_t              r;
        case (c.operation)
            OP_CLEAR:
            begin
                wipe_graph();
            end
            OP_MARK:
            begin
                station_marked[c.first_node] = 1'b1;
            end
            OP_EDGE:
            begin
                // A 16-bit weight never reaches "no path", so no clipping here.
                if (c.first_node != c.second_node)
                begin
                    dist_mat[ROAD_MAT][c.first_node][c.second_node] = dist_t'(c.edge_weight);
                    dist_mat[ROAD_MAT][c.second_node][c.first_node] = dist_t'(c.edge_weight);
                end
            end
            OP_COMPUTE:
            begin
                n = int'(cfg_nodes);
                if (n > MAX_NODES)
                begin
                    n = MAX_NODES;
                end
                if (n == 0)
                begin
                    n = 1;
                end
                // The road matrix stays closed after this, as in the block.
                close_matrix(ROAD_MAT, n);
                fill_matrix(STATION_MAT);
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        if (i != j && is_station(i) && is_station(j) &&
                            dist_mat[ROAD_MAT][i][j] != INF_DIST &&
                            dist_mat[ROAD_MAT][i][j] <= cfg_limit)
                        begin
                            dist_mat[STATION_MAT][i][j] = dist_mat[ROAD_MAT][i][j];
                        end
                    end
                end
                close_matrix(STATION_MAT, n);
                if (int'(cfg_source) >= n || int'(cfg_target) >= n)
                begin
                    d = INF_DIST;
                end
                else
                begin
                    d = dist_mat[STATION_MAT][cfg_source][cfg_target];
                end
                if (d == INF_DIST)
                begin
                    r.unreachable   = 1'b1;
                    r.path_distance = '1;
                    r.adjusted_cost = '0;
                end
                else
                begin
                    r.unreachable   = 1'b0;
                    r.path_distance = d;
                    cost = d;
                    if (d >= cfg_limit)
                    begin
                        cost = {d, 1'b0} - cfg_limit;
                    end
                    // d stays below "no path", so twice d fits the cost field.
                    r.adjusted_cost = cost[COST_BITS-1:0];
                end
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // One register write, with the predictor's copy updated alongside.
    task automatic write_reg(input cfg_reg_t index, input int value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_index      <= index;
        cfg_write_data <= value[CFG_DATA_BITS-1:0];
        case (index)
            REG_NODE_COUNT:  cfg_nodes  = value[COUNT_BITS-1:0];
            REG_RANGE_LIMIT: cfg_limit  = value[LIMIT_BITS-1:0];
            REG_SOURCE_NODE: cfg_source = value[NODE_FIELD_BITS-1:0];
            REG_TARGET_NODE: cfg_target = value[NODE_FIELD_BITS-1:0];
        endcase
    endtask

    // Write all four registers; ends just after a rising edge so that new
    // commands can be queued without racing the driver.
    task automatic configure(input int nodes, input int limit, input int src, input int tgt);
        write_reg(REG_NODE_COUNT, nodes);
        write_reg(REG_RANGE_LIMIT, limit);
        write_reg(REG_SOURCE_NODE, src);
        write_reg(REG_TARGET_NODE, tgt);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_cmd(input op_t op, input int u, input int v, input int w);
        command_t c;
        c.operation   = op;
        c.first_node  = u[NODE_FIELD_BITS-1:0];
        c.second_node = v[NODE_FIELD_BITS-1:0];
        c.edge_weight = w[WEIGHT_BITS-1:0];
        pending_commands.push_back(c);
        items_queued++;
    endtask

    // Wait until every command is taken, every result is in and the block
    // has finished. Clears and edges give no result, so busy and a short
    // margin cover them.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_commands.size() != 0 || in_flight ||
               expected_results.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    // A random graph under a random setting, ending in a compute.
    task automatic random_phase();
        int nodes;
        int span;
        int limit;
        int src;
        int tgt;
        int count;
        int pick;
        int u;
        int v;
        int w;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            nodes = 0;
        end
        else if (pick == 1)
        begin
            nodes = $urandom_range(9, 12);
        end
        else
        begin
            nodes = $urandom_range(1, 8);
        end
        span = (nodes == 0) ? 1 : nodes;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       limit = 0;
            1:       limit = LIMIT_NEAR_MAX;
            2:       limit = LIMIT_ALL_ONES;
            3:       limit = $urandom_range(0, LIMIT_ALL_ONES);
            default: limit = $urandom_range(0, 300);
        endcase
        src = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, span - 1);
        tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, span - 1);
        configure(nodes, limit, src, tgt);

        // Clears cost a full matrix pass, so only now and then.
        if ($urandom_range(0, 5) == 0)
        begin
            push_cmd(OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 65535));
        end
        count = $urandom_range(6, 16);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            u = $urandom_range(0, span - 1);
            v = $urandom_range(0, span - 1);
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
            if (pick < 55)
            begin
                push_cmd(OP_EDGE, u, v, w);
            end
            else if (pick < 72)
            begin
                push_cmd(OP_MARK, u, $urandom_range(0, 127), w);
            end
            else if (pick < 88)
            begin
                // Noise: any node numbers and weights, including unused ones.
                push_cmd(op_t'($urandom_range(1, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 65535));
            end
            else
            begin
                push_cmd(OP_COMPUTE, u, v, w);
            end
        end
        push_cmd(OP_COMPUTE, $urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 65535));
        wait_quiet();
    endtask

    // Driver: offers the next pending command at the falling edge and holds
    // it until the block takes it.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!in_flight)
        begin
            if (pending_commands.size() != 0 && $urandom_range(0, 99) >= gap_percent)
            begin
                command   <= pending_commands[0];
                start     <= 1'b1;
                in_flight = 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction, then records an accepted
    // command in the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    failures++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (result.unreachable !== oldest_result.unreachable)
                    begin
                        $error("unreachable: expected %0d, actual %0d",
                               oldest_result.unreachable, result.unreachable);
                        failures++;
                    end
                    if (result.path_distance !== oldest_result.path_distance)
                    begin
                        $error("path_distance: expected %0d, actual %0d",
                               oldest_result.path_distance, result.path_distance);
                        failures++;
                    end
                    if (result.adjusted_cost !== oldest_result.adjusted_cost)
                    begin
                        $error("adjusted_cost: expected %0d, actual %0d",
                               oldest_result.adjusted_cost, result.adjusted_cost);
                        failures++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_command(command);
                void'(pending_commands.pop_front());
                in_flight = 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = '0;
        cfg_write_en   = 1'b0;
        cfg_index      = REG_NODE_COUNT;
        cfg_write_data = '0;
        cfg_nodes      = 1;
        cfg_limit      = '0;
        cfg_source     = '0;
        cfg_target     = '0;
        wipe_graph();
        gap_percent    = 9;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        // Let the clearing pass after reset finish.
        wait_quiet();

        // Defaults: a single node that is both source and target.
        configure(1, 0, 0, 0);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        wait_quiet();

        // A node count of zero behaves as one.
        configure(0, 0, 0, 0);
        push_cmd(OP_COMPUTE, 127, 127, 65535);
        wait_quiet();

        // Small chain: self edge, overwrite, closure kept between computes,
        // extreme weights, a node beyond the count, then a clear.
        configure(4, 100, 0, 3);
        push_cmd(OP_EDGE, 0, 1, 40);
        push_cmd(OP_EDGE, 1, 2, 50);
        push_cmd(OP_EDGE, 2, 3, 30);
        push_cmd(OP_EDGE, 2, 2, 7);
        push_cmd(OP_MARK, 1, 0, 0);
        push_cmd(OP_MARK, 2, 127, 65535);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        push_cmd(OP_EDGE, 0, 1, 10);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        push_cmd(OP_EDGE, 1, 3, 65535);
        push_cmd(OP_EDGE, 0, 2, 0);
        push_cmd(OP_MARK, 127, 0, 0);
        push_cmd(OP_EDGE, 127, 0, 5);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        push_cmd(OP_CLEAR, 0, 0, 0);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        wait_quiet();

        // Source beyond the node count in use.
        configure(4, LIMIT_ALL_ONES, 127, 0);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        wait_quiet();

        // Zero limit with zero-weight roads through an unmarked node.
        configure(3, 0, 0, 2);
        push_cmd(OP_EDGE, 0, 1, 0);
        push_cmd(OP_EDGE, 1, 2, 0);
        push_cmd(OP_COMPUTE, 0, 0, 0);
        wait_quiet();

        // Random graphs; sender gaps change over the run, ending with none.
        while (items_queued < RANDOM_ITEMS)
        begin
            if (items_queued < RANDOM_ITEMS / 3)
            begin
                gap_percent = 9;
            end
            else if (items_queued < 2 * RANDOM_ITEMS / 3)
            begin
                gap_percent = 45;
            end
            else
            begin
                gap_percent = 0;
            end
            random_phase();
        end

        // One larger graph: a weighted chain plus random shortcuts.
        configure(BIG_NODES, LIMIT_NEAR_MAX, 0, BIG_NODES - 1);
        push_cmd(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < BIG_NODES - 1; i++)
        begin
            push_cmd(OP_EDGE, i, i + 1, $urandom_range(1000, 65535));
        end
        repeat (20)
        begin
            push_cmd(OP_EDGE, $urandom_range(0, BIG_NODES - 1), $urandom_range(0, BIG_NODES - 1),
                     $urandom_range(0, 65535));
        end
        repeat (16)
        begin
            push_cmd(OP_MARK, $urandom_range(0, BIG_NODES - 1), 0, 0);
        end
        push_cmd(OP_COMPUTE, 0, 0, 0);
        wait_quiet();

        repeat (END_CYCLES) @(negedge clk);
        if (failures == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/rlsp_pkg.sv
hw/rtl/rlsp_ram.sv
hw/rtl/rlsp_relax.sv
hw/rtl/range_limited_shortest_path.sv
tb/tb.sv
